// ===== rtl/core/gjsd_pkg.sv =====
// Shared types and codes for the gripper jaw settle detector.
`timescale 1ns / 1ps

package gjsd_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 32;

  typedef enum logic [0:0] {
    OP_BEGIN = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SETTLED  = 2'd1,
    EV_TIMEDOUT = 2'd2
  } event_t;

  localparam logic [IDX_W-1:0] REG_SETTLE_TOL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HOLD_TIME   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CLOSED_W    = 3'd2;
  localparam logic [IDX_W-1:0] REG_GRAB_MARGIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  localparam logic [POS_W-1:0]  RST_SETTLE_TOL  = 16'd500;
  localparam logic [TIME_W-1:0] RST_HOLD_TIME   = 32'd300000;
  localparam logic [POS_W-1:0]  RST_CLOSED_W    = 16'd0;
  localparam logic [POS_W-1:0]  RST_GRAB_MARGIN = 16'd2000;
  localparam logic [TIME_W-1:0] RST_TIMEOUT     = 32'd5000000;

  typedef struct packed {
    logic [POS_W-1:0]  settle_tol;
    logic [TIME_W-1:0] hold_time;
    logic [POS_W-1:0]  closed_w;
    logic [POS_W-1:0]  grab_margin;
    logic [TIME_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic              armed;
    logic [TIME_W-1:0] armed_time;
    logic [TIME_W-1:0] last_seen_time;
    logic              still_valid;
    logic [TIME_W-1:0] still_start_time;
    logic [POS_W-1:0]  still_ref;
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [TIME_W-1:0] sample_time;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    event_t           event_res;
    logic             grabbed;
    logic [POS_W-1:0] stop_position;
    logic [POS_W-1:0] gap_to_closed;
  } result_t;

endpackage

// ===== rtl/core/gjsd_cfg.sv =====
// Configuration register file for the settle detector.
`timescale 1ns / 1ps

module gjsd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gjsd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gjsd_pkg::CFG_W-1:0]  cfg_wdata,
  output gjsd_pkg::cfg_t              cfg
);

  gjsd_pkg::cfg_t cfg_r;
  gjsd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gjsd_pkg::REG_SETTLE_TOL:  cfg_nxt.settle_tol  = cfg_wdata[gjsd_pkg::POS_W-1:0];
        gjsd_pkg::REG_HOLD_TIME:   cfg_nxt.hold_time   = cfg_wdata[gjsd_pkg::TIME_W-1:0];
        gjsd_pkg::REG_CLOSED_W:    cfg_nxt.closed_w    = cfg_wdata[gjsd_pkg::POS_W-1:0];
        gjsd_pkg::REG_GRAB_MARGIN: cfg_nxt.grab_margin = cfg_wdata[gjsd_pkg::POS_W-1:0];
        gjsd_pkg::REG_TIMEOUT:     cfg_nxt.timeout     = cfg_wdata[gjsd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_tol  <= gjsd_pkg::RST_SETTLE_TOL;
      cfg_r.hold_time   <= gjsd_pkg::RST_HOLD_TIME;
      cfg_r.closed_w    <= gjsd_pkg::RST_CLOSED_W;
      cfg_r.grab_margin <= gjsd_pkg::RST_GRAB_MARGIN;
      cfg_r.timeout     <= gjsd_pkg::RST_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/gjsd_eval.sv =====
// Per-word decision logic: next detector state and the result word.
`timescale 1ns / 1ps

module gjsd_eval (
  input  gjsd_pkg::item_t   item,
  input  gjsd_pkg::state_t  st,
  input  gjsd_pkg::cfg_t    cfg,
  output gjsd_pkg::state_t  st_nxt,
  output gjsd_pkg::result_t res
);

  logic                        fresh;
  logic [gjsd_pkg::POS_W-1:0]  diff;
  logic                        moved;
  logic [gjsd_pkg::TIME_W-1:0] held_for;
  logic                        settle_due;
  logic [gjsd_pkg::TIME_W-1:0] since_arm;
  logic                        timeout_due;
  logic [gjsd_pkg::POS_W:0]    grab_limit;

  always_comb begin
    fresh = (item.sample_time > st.armed_time) && (item.sample_time != st.last_seen_time);
    diff  = (item.position > st.still_ref) ? (item.position - st.still_ref)
                                           : (st.still_ref - item.position);
    moved = !st.still_valid || (diff > cfg.settle_tol);
    held_for   = item.sample_time - st.still_start_time;
    settle_due = (item.sample_time >= st.still_start_time) && (held_for >= cfg.hold_time);
    since_arm   = item.now - st.armed_time;
    timeout_due = (item.now >= st.armed_time) && (since_arm >= cfg.timeout);
    grab_limit  = {1'b0, cfg.closed_w} + {1'b0, cfg.grab_margin};
  end

  always_comb begin
    st_nxt = st;
    res    = '{event_res: gjsd_pkg::EV_NONE, grabbed: 1'b0,
               stop_position: '0, gap_to_closed: '0};
    case (item.op)
      gjsd_pkg::OP_BEGIN: begin
        st_nxt.armed          = 1'b1;
        st_nxt.armed_time     = item.now;
        st_nxt.last_seen_time = '0;
        st_nxt.still_valid    = 1'b0;
      end
      gjsd_pkg::OP_TICK: begin
        if (st.armed) begin
          if (fresh) begin
            st_nxt.last_seen_time = item.sample_time;
          end
          if (fresh && moved) begin
            st_nxt.still_ref        = item.position;
            st_nxt.still_start_time = item.sample_time;
            st_nxt.still_valid      = 1'b1;
          end
          if (fresh && !moved && settle_due) begin
            // settled verdict beats a timeout on the same word
            st_nxt.armed      = 1'b0;
            res.event_res     = gjsd_pkg::EV_SETTLED;
            res.grabbed       = {1'b0, item.position} > grab_limit;
            res.stop_position = item.position;
            res.gap_to_closed = (item.position > cfg.closed_w) ?
                                (item.position - cfg.closed_w) : '0;
          end else if (timeout_due) begin
            st_nxt.armed  = 1'b0;
            res.event_res = gjsd_pkg::EV_TIMEDOUT;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/gripper_jaw_settle_detector.sv =====
// Gripper jaw settle detector: one word in, one verdict word out, every cycle unless stalled.
// A word is accepted each cycle while the result side keeps up; its result
// word passes from the input register to the result register, with the
// detector state updated in the single logic stage between them. Stall on the
// result side holds the result register and, through it, the input register.
// Configuration writes take effect on the next cycle and are only to be issued
// while no word is in flight.
`timescale 1ns / 1ps

module gripper_jaw_settle_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gjsd_pkg::IDX_W-1:0]         cfg_index,
  input  logic [gjsd_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [gjsd_pkg::POS_W-1:0]         in_position,
  input  logic [gjsd_pkg::TIME_W-1:0]        in_sample_time,
  input  logic [gjsd_pkg::TIME_W-1:0]        in_now,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_event_res,
  output logic                               out_grabbed,
  output logic [gjsd_pkg::POS_W-1:0]         out_stop_position,
  output logic [gjsd_pkg::POS_W-1:0]         out_gap_to_closed
);

  gjsd_pkg::cfg_t    cfg;
  gjsd_pkg::state_t  st_r;
  gjsd_pkg::state_t  st_nxt;
  gjsd_pkg::item_t   item_r;
  logic              item_vld_r;
  gjsd_pkg::result_t res;
  gjsd_pkg::result_t res_r;
  logic              res_vld_r;
  logic              advance;
  logic              in_take;

  gjsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gjsd_eval u_eval (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // word in the input register moves on when the result slot is free
  assign advance  = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = item_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op          <= gjsd_pkg::op_t'(in_op);
      item_r.position    <= in_position;
      item_r.sample_time <= in_sample_time;
      item_r.now         <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (!out_stall) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_event_res     = res_r.event_res;
  assign out_grabbed       = res_r.grabbed;
  assign out_stop_position = res_r.stop_position;
  assign out_gap_to_closed = res_r.gap_to_closed;

endmodule
